// ----- rtl/core/msbr_pkg.sv -----
// Shared constants and types for the masked status bit reporter.
package msbr_pkg;

   localparam int WORD_BITS     = 16;
   localparam int DEF_NUM_WORDS = 8;
   localparam int CMD_W         = 2;
   localparam int ID_W          = 7;
   localparam int LIMIT_W       = 8;
   localparam int WIDX_W        = 3;
   localparam int CSR_IDX_W     = 1;

   localparam logic [WORD_BITS-1:0] FULL_WORD = 16'hFFFF;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [WORD_BITS-1:0] word_type;

   localparam cmd_type CMD_SET    = 2'd0;
   localparam cmd_type CMD_CLEAR  = 2'd1;
   localparam cmd_type CMD_CONFIG = 2'd2;
   localparam cmd_type CMD_REPORT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ID_LIMIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_MODE = 1'd1;

endpackage

// ----- rtl/core/masked_status_bit_reporter.sv -----
// Masked status bit reporter: enable, current and report stores with word-serial report.
//
//   channel | direction | handshake            | beat
//   req_    | in        | req_valid/req_ready  | command, bit_id, all_ids, enable
//   rsp_    | out       | rsp_valid/rsp_ready  | status, word_index, report_word, last
//   csr_    | in        | csr_write            | csr_index, csr_wdata
//
// Set, clear and configure of one bit: accept, memory read, then write back and respond.
// Report: one word read, merged, written back and sent per cycle while the rsp_ slot is free.
// Enable-all: one enable word written per cycle.
// Reset clears the per-word valid bits at once; no clearing pass.
// A stalled rsp_ beat holds the report word loop; one item is in work at a time.
module masked_status_bit_reporter #(
   parameter int NUM_WORDS = msbr_pkg::DEF_NUM_WORDS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  msbr_pkg::cmd_type                   req_command,
   input  logic [msbr_pkg::ID_W-1:0]           req_bit_id,
   input  logic                                req_all_ids,
   input  logic                                req_enable,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_status,
   output logic [msbr_pkg::WIDX_W-1:0]         rsp_word_index,
   output msbr_pkg::word_type                  rsp_report_word,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [msbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msbr_pkg::LIMIT_W-1:0]        csr_wdata
);
   import msbr_pkg::*;

   localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CAP   = NUM_WORDS * WORD_BITS;
   localparam int LIM_W = ($clog2(CAP + 1) > LIMIT_W) ? $clog2(CAP + 1) : LIMIT_W;
   localparam int FW    = LIM_W - 4;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RESP = 3'd1;
   localparam logic [2:0] S_RMW  = 3'd2;
   localparam logic [2:0] S_RPT  = 3'd3;
   localparam logic [2:0] S_FILL = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       addr_ff, addr_in;
   cmd_type             cmd_ff, cmd_in;
   word_type            mask_ff, mask_in;
   logic                en_ff, en_in;
   logic                status_ff, status_in;

   logic [LIMIT_W-1:0]  id_limit_ff;
   logic                mode_ff;

   logic [NUM_WORDS-1:0] en_vld_ff, en_vld_in;
   logic [NUM_WORDS-1:0] cr_vld_ff, cr_vld_in;

   word_type            en_mem [NUM_WORDS];
   logic [2*WORD_BITS-1:0] cr_mem [NUM_WORDS];
   word_type            en_rd_ff;
   logic [2*WORD_BITS-1:0] cr_rd_ff;

   logic                en_we, cr_we;
   word_type            en_wd;
   logic [2*WORD_BITS-1:0] cr_wd;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [WIDX_W-1:0]   rsp_widx_ff, rsp_widx_in;
   word_type            rsp_word_ff, rsp_word_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [LIM_W-1:0]    eff_lim;
   logic                id_ok;
   logic [FW-1:0]       fill_full;
   logic [3:0]          fill_rem;
   logic [AW-1:0]       fill_end;
   word_type            fill_word;
   word_type            cur_en, cur_c, cur_r, new_r;
   logic                slot_free;

   assign eff_lim   = (LIM_W'(id_limit_ff) < LIM_W'(CAP)) ? LIM_W'(id_limit_ff) : LIM_W'(CAP);
   assign id_ok     = LIM_W'(req_bit_id) < eff_lim;
   assign fill_full = eff_lim[LIM_W-1:4];
   assign fill_rem  = eff_lim[3:0];
   assign fill_end  = (int'(fill_full) < NUM_WORDS) ? AW'(fill_full) : LAST_ADDR;
   assign fill_word = (int'(addr_ff) < int'(fill_full)) ? FULL_WORD : ~(FULL_WORD << fill_rem);

   assign cur_en = en_vld_ff[addr_ff] ? en_rd_ff : '0;
   assign cur_c  = cr_vld_ff[addr_ff] ? cr_rd_ff[2*WORD_BITS-1:WORD_BITS] : '0;
   assign cur_r  = cr_vld_ff[addr_ff] ? cr_rd_ff[WORD_BITS-1:0] : '0;
   assign new_r  = mode_ff ? (cur_r | cur_c) : cur_c;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      cmd_in        = cmd_ff;
      mask_in       = mask_ff;
      en_in         = en_ff;
      status_in     = status_ff;
      en_vld_in     = en_vld_ff;
      cr_vld_in     = cr_vld_ff;
      en_we         = 1'b0;
      cr_we         = 1'b0;
      en_wd         = '0;
      cr_wd         = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_widx_in   = rsp_widx_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               en_in     = req_enable;
               mask_in   = word_type'(1) << req_bit_id[3:0];
               status_in = 1'b0;
               if (req_command == CMD_REPORT) begin
                  addr_in  = '0;
                  state_in = S_RPT;
               end else if (req_all_ids && req_command == CMD_CLEAR) begin
                  cr_vld_in = '0;
                  state_in  = S_RESP;
               end else if (req_all_ids && req_command == CMD_CONFIG) begin
                  if (req_enable) begin
                     addr_in  = '0;
                     state_in = S_FILL;
                  end else begin
                     en_vld_in = '0;
                     state_in  = S_RESP;
                  end
               end else if (id_ok) begin
                  addr_in  = AW'(req_bit_id >> 4);
                  state_in = S_RMW;
               end else begin
                  status_in = 1'b1;
                  state_in  = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_widx_in   = '0;
               rsp_word_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RMW: begin
            if (slot_free) begin
               case (cmd_ff)
                  CMD_SET: begin
                     cr_we = 1'b1;
                     cr_wd = {cur_c | (mask_ff & cur_en), cur_r};
                  end
                  CMD_CLEAR: begin
                     cr_we = 1'b1;
                     cr_wd = {cur_c & ~mask_ff, cur_r & ~mask_ff};
                  end
                  CMD_CONFIG: begin
                     en_we = 1'b1;
                     en_wd = en_ff ? (cur_en | mask_ff) : (cur_en & ~mask_ff);
                  end
                  default: begin
                     cr_we = 1'b0;
                  end
               endcase
               if (cr_we) begin
                  cr_vld_in[addr_ff] = 1'b1;
               end
               if (en_we) begin
                  en_vld_in[addr_ff] = 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_widx_in   = '0;
               rsp_word_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RPT: begin
            if (slot_free) begin
               cr_we              = 1'b1;
               cr_wd              = {word_type'(0), new_r};
               cr_vld_in[addr_ff] = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_status_in      = 1'b0;
               rsp_widx_in        = WIDX_W'(addr_ff);
               rsp_word_in        = new_r;
               rsp_last_in        = (addr_ff == LAST_ADDR);
               if (addr_ff == LAST_ADDR) begin
                  state_in = S_IDLE;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
         end
         S_FILL: begin
            en_we              = 1'b1;
            en_wd              = fill_word;
            en_vld_in[addr_ff] = 1'b1;
            if (addr_ff == fill_end) begin
               state_in = S_RESP;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      en_rd_ff <= en_mem[addr_in];
      cr_rd_ff <= cr_mem[addr_in];
      if (en_we) begin
         en_mem[addr_ff] <= en_wd;
      end
      if (cr_we) begin
         cr_mem[addr_ff] <= cr_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         en_vld_ff    <= '0;
         cr_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         id_limit_ff  <= LIMIT_W'(128);
         mode_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         en_vld_ff    <= en_vld_in;
         cr_vld_ff    <= cr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_ID_LIMIT:    id_limit_ff <= csr_wdata;
               CSR_REPORT_MODE: mode_ff     <= csr_wdata[0];
               default:         mode_ff     <= mode_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      cmd_ff        <= cmd_in;
      mask_ff       <= mask_in;
      en_ff         <= en_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_widx_ff   <= rsp_widx_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_word_index  = rsp_widx_ff;
   assign rsp_report_word = rsp_word_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the masked status bit reporter: directed and random command beats checked.
`timescale 1ns / 100ps

module tb_top;
   import msbr_pkg::*;

   localparam int NUM_WORDS   = DEF_NUM_WORDS;
   localparam int ID_SPACE    = NUM_WORDS * WORD_BITS;
   localparam int SETTLE      = NUM_WORDS + 4;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic              status;
      logic [WIDX_W-1:0] word_index;
      word_type          report_word;
      logic              last;
   } status_beat_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   cmd_type              req_command = CMD_SET;
   logic [ID_W-1:0]      req_bit_id  = '0;
   logic                 req_all_ids = 1'b0;
   logic                 req_enable  = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic                 rsp_status;
   logic [WIDX_W-1:0]    rsp_word_index;
   word_type             rsp_report_word;
   logic                 rsp_last;
   logic                 csr_write   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_ID_LIMIT;
   logic [LIMIT_W-1:0]   csr_wdata   = '0;

   word_type        en_words  [NUM_WORDS];
   word_type        cur_words [NUM_WORDS];
   word_type        rep_words [NUM_WORDS];
   int unsigned     limit_reg;
   logic            merge_mode;
   status_beat_type pending_beats[$];
   int              mismatches   = 0;
   bit              pace_on      = 1'b1;
   int              holdoff_len  = 0;
   int              quiet_cycles = 0;

   masked_status_bit_reporter #(.NUM_WORDS(NUM_WORDS)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_bit_id      (req_bit_id),
      .req_all_ids     (req_all_ids),
      .req_enable      (req_enable),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_word_index  (rsp_word_index),
      .rsp_report_word (rsp_report_word),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!pace_on || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned eff_limit();
      return (limit_reg < ID_SPACE) ? limit_reg : ID_SPACE;
   endfunction

   task automatic predict_command(cmd_type cmd, logic [ID_W-1:0] id, logic all, logic en);
      status_beat_type beat;
      int unsigned     w;
      int unsigned     full;
      int unsigned     rem;
      word_type        m;
      logic            hit;
      beat = '0;
      beat.last = 1'b1;
      w   = id / WORD_BITS;
      m   = word_type'(1) << (id % WORD_BITS);
      hit = (id < eff_limit());
      case (cmd)
         CMD_REPORT: begin
            for (int i = 0; i < NUM_WORDS; i++) begin
               rep_words[i] = merge_mode ? (rep_words[i] | cur_words[i]) : cur_words[i];
               cur_words[i] = '0;
               beat.word_index  = WIDX_W'(i);
               beat.report_word = rep_words[i];
               beat.last        = (i == NUM_WORDS - 1);
               pending_beats.push_back(beat);
            end
         end
         CMD_SET: begin
            if (!hit) beat.status = 1'b1;
            else if ((en_words[w] & m) != '0) cur_words[w] |= m;
         end
         CMD_CLEAR: begin
            if (all) begin
               for (int i = 0; i < NUM_WORDS; i++) begin
                  cur_words[i] = '0;
                  rep_words[i] = '0;
               end
            end else if (hit) begin
               cur_words[w] &= ~m;
               rep_words[w] &= ~m;
            end else begin
               beat.status = 1'b1;
            end
         end
         default: begin
            if (all && en) begin
               full = eff_limit() / WORD_BITS;
               rem  = eff_limit() % WORD_BITS;
               for (int i = 0; i < NUM_WORDS; i++)
                  if (i < full) en_words[i] = FULL_WORD;
               if (full < NUM_WORDS) en_words[full] = (word_type'(1) << rem) - 1'b1;
            end else if (all) begin
               for (int i = 0; i < NUM_WORDS; i++) en_words[i] = '0;
            end else if (hit) begin
               if (en) en_words[w] |= m;
               else en_words[w] &= ~m;
            end else begin
               beat.status = 1'b1;
            end
         end
      endcase
      if (cmd != CMD_REPORT) pending_beats.push_back(beat);
   endtask

   task automatic send_cmd(cmd_type cmd, logic [ID_W-1:0] id, logic all, logic en);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_bit_id  <= id;
      req_all_ids <= all;
      req_enable  <= en;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_command(cmd, id, all, en);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_ID_LIMIT) limit_reg = 32'(data);
      else merge_mode = data[0];
      @(posedge clock);
   endtask

   task automatic reconfigure(int unsigned lim, bit mode);
      drain_and_settle();
      write_csr(CSR_ID_LIMIT, LIMIT_W'(lim));
      write_csr(CSR_REPORT_MODE, LIMIT_W'(mode));
   endtask

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch exp %0h got %0h", $time, what, want, got);
      end
   endtask

   task automatic test_directed();
      send_cmd(CMD_SET, 7'd5, 1'b0, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_CONFIG, 7'd0, 1'b1, 1'b1);
      send_cmd(CMD_SET, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_SET, 7'd127, 1'b0, 1'b0);
      send_cmd(CMD_SET, 7'd64, 1'b1, 1'b1);
      send_cmd(CMD_REPORT, 7'd127, 1'b1, 1'b1);
      send_cmd(CMD_SET, 7'd17, 1'b0, 1'b0);
      send_cmd(CMD_CLEAR, 7'd17, 1'b0, 1'b0);
      send_cmd(CMD_SET, 7'd31, 1'b0, 1'b1);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_CLEAR, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_CONFIG, 7'd127, 1'b0, 1'b0);
      send_cmd(CMD_SET, 7'd127, 1'b0, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_CLEAR, 7'd99, 1'b1, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_CONFIG, 7'd3, 1'b1, 1'b0);
      send_cmd(CMD_SET, 7'd3, 1'b0, 1'b0);
      send_cmd(CMD_CONFIG, 7'd3, 1'b0, 1'b1);
      send_cmd(CMD_SET, 7'd3, 1'b0, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
   endtask

   task automatic test_limits();
      int unsigned lims[9] = '{0, 1, 15, 16, 17, 100, 127, 128, 200};
      foreach (lims[k]) begin
         reconfigure(lims[k], 1'(k % 2));
         send_cmd(CMD_CONFIG, 7'd0, 1'b1, 1'b1);
         if (lims[k] > 0) send_cmd(CMD_SET, ID_W'(lims[k] - 1), 1'b0, 1'b0);
         send_cmd(CMD_SET, ID_W'(lims[k]), 1'b0, 1'b0);
         send_cmd(CMD_CONFIG, ID_W'(lims[k]), 1'b0, 1'b1);
         send_cmd(CMD_CLEAR, ID_W'(lims[k]), 1'b0, 1'b0);
         send_cmd(CMD_SET, 7'd127, 1'b0, 1'b0);
         send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
         send_cmd(CMD_CLEAR, 7'd0, 1'b1, 1'b1);
         send_cmd(CMD_CONFIG, 7'd0, 1'b1, 1'b0);
      end
   endtask

   task automatic test_modes();
      reconfigure(128, 1'b1);
      send_cmd(CMD_CONFIG, 7'd0, 1'b1, 1'b1);
      send_cmd(CMD_SET, 7'd1, 1'b0, 1'b0);
      send_cmd(CMD_SET, 7'd120, 1'b0, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_SET, 7'd2, 1'b0, 1'b0);
      send_cmd(CMD_SET, 7'd77, 1'b0, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_CLEAR, 7'd1, 1'b0, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
      send_cmd(CMD_SET, 7'd121, 1'b0, 1'b0);
      reconfigure(16, 1'b1);
      send_cmd(CMD_SET, 7'd122, 1'b0, 1'b0);
      send_cmd(CMD_CLEAR, 7'd120, 1'b0, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
      reconfigure(128, 1'b0);
      send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
   endtask

   task automatic test_backpressure();
      reconfigure(128, 1'b0);
      pace_on = 1'b0;
      send_cmd(CMD_CONFIG, 7'd0, 1'b1, 1'b1);
      holdoff_len = 300;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2) send_cmd(CMD_REPORT, 7'd0, 1'b0, 1'b0);
         else send_cmd(CMD_SET, ID_W'($urandom), 1'b0, 1'b0);
      end
      drain_and_settle();
      pace_on = 1'b1;
   endtask

   task automatic test_random(int total);
      int          sent;
      int          burst;
      int          roll;
      int unsigned lim;
      cmd_type     cmd;
      logic [ID_W-1:0] id;
      logic        all;
      logic        en;
      sent = 0;
      while (sent < total) begin
         roll = $urandom_range(0, 9);
         lim  = (roll == 0) ? 128 : (roll == 1) ? 255 : $urandom_range(0, 128);
         reconfigure(lim, 1'($urandom_range(0, 1)));
         pace_on = ($urandom_range(0, 3) != 0);
         burst = $urandom_range(20, 40);
         for (int i = 0; i < burst && sent < total; i++) begin
            roll = $urandom_range(0, 99);
            cmd  = (roll < 40) ? CMD_SET : (roll < 55) ? CMD_CLEAR :
                   (roll < 80) ? CMD_CONFIG : CMD_REPORT;
            if ($urandom_range(0, 3) == 0) id = ID_W'(limit_reg + $urandom_range(0, 2) - 1);
            else id = ID_W'($urandom);
            if (cmd == CMD_CLEAR) all = ($urandom_range(0, 9) == 0);
            else if (cmd == CMD_CONFIG) all = ($urandom_range(0, 3) == 0);
            else all = 1'($urandom_range(0, 1));
            en = (cmd == CMD_CONFIG) ? ($urandom_range(0, 3) != 0) :
                 1'($urandom_range(0, 1));
            send_cmd(cmd, id, all, en);
            sent++;
         end
      end
      pace_on = 1'b1;
   endtask

   always @(posedge clock) begin : rsp_checker
      status_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_beats.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat exp none got idx %0d word %h last %b",
                     $time, rsp_word_index, rsp_report_word, rsp_last);
         end else begin
            want = pending_beats.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("word_index", want.word_index, rsp_word_index);
            check_field("report_word", want.report_word, rsp_report_word);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   initial begin : rsp_pacer
      int gap;
      forever begin
         @(posedge clock);
         if (holdoff_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (holdoff_len) @(posedge clock);
            holdoff_len = 0;
            rsp_ready <= 1'b1;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      limit_reg  = ID_SPACE;
      merge_mode = 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         en_words[i]  = '0;
         cur_words[i] = '0;
         rep_words[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      test_modes();
      test_backpressure();
      test_random(80);
      drain_and_settle();
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- masked_status_bit_reporter.f -----
rtl/core/msbr_pkg.sv
rtl/core/masked_status_bit_reporter.sv
bench/tb_top.sv
